// ----- src/fa48_pkg.sv -----
// Shared types and constants for the 48-bit float adder.
// Used by the align/add stage, the normalize stage and the top level.
package fa48_pkg;

    localparam logic [14:0] EXP_MASK = 15'h7FFF;
    localparam logic [31:0] MANT_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] MANT_MSB = 32'h8000_0000;

    // Result status codes
    localparam logic [1:0] ST_EXACT = 2'd0;
    localparam logic [1:0] ST_INEXACT = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_UNDERFLOW = 2'd3;

    // Raw sum out of the align/add stage, before carry handling and normalization
    typedef struct packed {
        logic        sign;
        logic [14:0] exp_max;
        logic        carry;
        logic        lost;
        logic [31:0] mant;
    } sum_t;

    // Packed result item
    typedef struct packed {
        logic [15:0] sign_exp;
        logic [31:0] mantissa;
        logic [1:0]  status;
    } res_t;

endpackage

// ----- src/fa48_channels.sv -----
// Valid/ready channel interfaces for operand and result items of the 48-bit float adder.
// No dependencies.
interface fa48_operand_if;
    logic        valid;
    logic        ready;
    logic [15:0] a_sign_exp;
    logic [31:0] a_mantissa;
    logic [15:0] b_sign_exp;
    logic [31:0] b_mantissa;

    modport source (output valid, a_sign_exp, a_mantissa, b_sign_exp, b_mantissa,
                    input ready);
    modport sink (input valid, a_sign_exp, a_mantissa, b_sign_exp, b_mantissa,
                  output ready);
endinterface

interface fa48_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_sign_exp;
    logic [31:0] result_mantissa;
    logic [1:0]  status;

    modport source (output valid, result_sign_exp, result_mantissa, status, input ready);
    modport sink (input valid, result_sign_exp, result_mantissa, status, output ready);
endinterface

// ----- src/float48_add_sticky_normalize.sv -----
// 48-bit float adder: an accepted operand item is held in the input register, then
// in the result register (2 register stages), from which the result channel offers it.
// Throughput one item per cycle unless stalled: input register, one pass of
// align/add/normalize logic, result register, which frees while its item is taken.
// rst_n (async, active low) clears both valid flags; payload registers are not reset.
// Depends on fa48_pkg, fa48_channels, fa48_align and fa48_norm.
module float48_add_sticky_normalize (
    input  logic                  clk,
    input  logic                  rst_n,
    fa48_operand_if.sink          operand,
    fa48_result_if.source         result
);
    import fa48_pkg::*;

    // Input stage
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [15:0] a_se_reg;
    logic [31:0] a_m_reg;
    logic [15:0] b_se_reg;
    logic [31:0] b_m_reg;

    // Result stage
    logic        out_valid_reg;
    logic        out_valid_next;
    res_t        out_reg;

    sum_t        sum;
    res_t        res;
    logic        advance;
    logic        take;

    // The result register can load when empty or when its item leaves this cycle
    assign advance = !out_valid_reg || result.ready;
    // The input register can load when empty or when it moves on to the result stage
    assign operand.ready = !in_valid_reg || advance;
    assign take = operand.valid && operand.ready;

    assign in_valid_next = operand.ready ? operand.valid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture operands on accept
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_se_reg <= operand.a_sign_exp;
            a_m_reg <= operand.a_mantissa;
            b_se_reg <= operand.b_sign_exp;
            b_m_reg <= operand.b_mantissa;
        end
    end

    // Align, add, sticky fold
    fa48_align u_align (
        .a_sign_exp (a_se_reg),
        .a_mantissa (a_m_reg),
        .b_sign_exp (b_se_reg),
        .b_mantissa (b_m_reg),
        .sum        (sum)
    );

    // Carry, normalize, range check, pack
    fa48_norm u_norm (
        .sum (sum),
        .res (res)
    );

    // Hold the result while stalled; load a fresh one when the stage advances
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_reg <= res;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.result_sign_exp = out_reg.sign_exp;
    assign result.result_mantissa = out_reg.mantissa;
    assign result.status = out_reg.status;

`ifndef SYNTH
    // An operand item in the input register moves to the result stage when it is free
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && advance |=> out_valid_reg)
        else $error("input item not moved to result stage");

    // Saturated overflow carries the all-ones mantissa and exponent
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == ST_OVERFLOW |->
            result.result_mantissa == MANT_ONES && result.result_sign_exp[14:0] == EXP_MASK)
        else $error("overflow result not saturated");

    // Underflow flushes mantissa and exponent to zero
    a_unf: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == ST_UNDERFLOW |->
            result.result_mantissa == 32'd0 && result.result_sign_exp[14:0] == 15'd0)
        else $error("underflow result not flushed");

    // In-range nonzero results are normalized; zero results pack as word 0
    a_norm: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.status == ST_EXACT || result.status == ST_INEXACT) |->
            result.result_mantissa[31] ||
            (result.result_mantissa == 32'd0 && result.result_sign_exp == 16'd0))
        else $error("result not normalized");
`endif

endmodule

// ----- src/fa48_align.sv -----
// Exponent compare, sticky right alignment and mantissa add/subtract.
// Depends on fa48_pkg.
module fa48_align (
    input  logic [15:0]    a_sign_exp,
    input  logic [31:0]    a_mantissa,
    input  logic [15:0]    b_sign_exp,
    input  logic [31:0]    b_mantissa,
    output fa48_pkg::sum_t sum
);
    import fa48_pkg::*;

    // Shift right by d; top bit of the result flags ones shifted out.
    function automatic logic [32:0] shift_sticky(input logic [31:0] m, input logic [14:0] d);
        logic [31:0] mask;
        mask = ~(MANT_ONES << d[4:0]);
        if (d >= 15'd32)
            return {(m != 32'd0), 32'd0};
        return {((m & mask) != 32'd0), m >> d[4:0]};
    endfunction

    logic [14:0] ea;
    logic [14:0] eb;
    logic        sa;
    logic        sb;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [32:0] shifted;
    logic        lost;
    logic [32:0] add33;
    logic [31:0] r;

    always_comb
    begin
        ea = a_sign_exp[14:0];
        eb = b_sign_exp[14:0];
        sa = a_sign_exp[15];
        sb = b_sign_exp[15];
        ma = a_mantissa;
        mb = b_mantissa;
        lost = 1'b0;
        shifted = '0;
        sum = '0;

        // Align the operand with the smaller exponent
        if (ea > eb)
        begin
            shifted = shift_sticky(b_mantissa, ea - eb);
            mb = shifted[31:0];
            lost = shifted[32];
            sum.exp_max = ea;
        end
        else if (eb > ea)
        begin
            shifted = shift_sticky(a_mantissa, eb - ea);
            ma = shifted[31:0];
            lost = shifted[32];
            sum.exp_max = eb;
        end
        else
        begin
            sum.exp_max = ea;
        end

        add33 = {1'b0, ma} + {1'b0, mb};
        if (sa == sb)
        begin
            sum.sign = sa;
            r = add33[31:0];
            sum.carry = add33[32];
        end
        else if (ma >= mb)
        begin
            sum.sign = sa;
            r = ma - mb;
            sum.carry = 1'b0;
        end
        else
        begin
            sum.sign = sb;
            r = mb - ma;
            sum.carry = 1'b0;
        end

        // Fold the sticky bit into the lsb before the carry shift
        sum.mant = r | {31'd0, lost};
        sum.lost = lost;
    end

endmodule

// ----- src/fa48_norm.sv -----
// Carry handling, leading-zero normalization, exponent range check and result packing.
// Depends on fa48_pkg.
module fa48_norm (
    input  fa48_pkg::sum_t sum,
    output fa48_pkg::res_t res
);
    import fa48_pkg::*;

    logic [31:0]        m0;
    logic [31:0]        m1;
    logic [31:0]        m2;
    logic [31:0]        m3;
    logic [31:0]        m4;
    logic [31:0]        m5;
    logic [4:0]         lz;
    logic               zero;
    logic signed [16:0] exp_b;

    always_comb
    begin
        // Carry out: shift right, set the msb, bump the exponent
        m0 = sum.carry ? ((sum.mant >> 1) | MANT_MSB) : sum.mant;
        zero = (m0 == 32'd0);

        // Log shifter: strip leading zeros in steps of 16, 8, 4, 2, 1
        lz[4] = (m0[31:16] == 16'd0);
        m1 = lz[4] ? (m0 << 16) : m0;
        lz[3] = (m1[31:24] == 8'd0);
        m2 = lz[3] ? (m1 << 8) : m1;
        lz[2] = (m2[31:28] == 4'd0);
        m3 = lz[2] ? (m2 << 4) : m2;
        lz[1] = (m3[31:30] == 2'd0);
        m4 = lz[1] ? (m3 << 2) : m3;
        lz[0] = !m4[31];
        m5 = lz[0] ? (m4 << 1) : m4;

        exp_b = $signed({2'b00, sum.exp_max}) + $signed({16'd0, sum.carry})
              - $signed({12'd0, lz});

        if (zero)
        begin
            res.sign_exp = 16'd0;
            res.mantissa = 32'd0;
            res.status = ST_EXACT;
        end
        else if (exp_b > $signed({2'b00, EXP_MASK}))
        begin
            res.sign_exp = {sum.sign, EXP_MASK};
            res.mantissa = MANT_ONES;
            res.status = ST_OVERFLOW;
        end
        else if (exp_b < 17'sd0)
        begin
            res.sign_exp = {sum.sign, 15'd0};
            res.mantissa = 32'd0;
            res.status = ST_UNDERFLOW;
        end
        else
        begin
            res.sign_exp = {sum.sign, exp_b[14:0]};
            res.mantissa = m5;
            res.status = sum.lost ? ST_INEXACT : ST_EXACT;
        end
    end

endmodule
